>>> src/kdt_pkg.sv
// kdt_pkg: shared widths, item kind codes, walker state and result types
// for the k-d tree point locator; depends on nothing
package kdt_pkg;

  localparam int unsigned DEF_MAX_POINTS = 1024;

  localparam int unsigned CNT_W   = 11;  // point_count register
  localparam int unsigned PW_W    = 12;  // level power, up to twice the count
  localparam int unsigned IDX_W   = 10;  // entry_index field
  localparam int unsigned COORD_W = 32;  // signed q16.16
  localparam int unsigned RANK_W  = 11;  // signed rank entry, negative is empty
  localparam int unsigned PT_W    = 10;  // point_index field

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_SPLIT = 2'd1;
  localparam logic [1:0] KIND_RANK  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LEAF
  } walk_state_e;

  typedef struct packed {
    logic            valid;
    logic            miss;
    logic [PT_W-1:0] point_index;
  } res_t;

endpackage

>>> src/kdt_if.sv
// kdt_if: valid/ready channel interfaces for the query, result and
// configuration ports; depends on kdt_pkg
interface kdt_in_if import kdt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;
  logic [IDX_W-1:0]          entry_index;
  logic signed [COORD_W-1:0] split_value;
  logic signed [RANK_W-1:0]  rank_point;

  modport source (output valid, kind, query_x, query_y, entry_index, split_value,
                  rank_point, input ready);
  modport sink   (input valid, kind, query_x, query_y, entry_index, split_value,
                  rank_point, output ready);
endinterface

interface kdt_out_if import kdt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PT_W-1:0] point_index;
  logic            miss;

  modport source (output valid, point_index, miss, input ready);
  modport sink   (input valid, point_index, miss, output ready);
endinterface

interface kdt_cfg_if import kdt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> src/kdt_ram.sv
// kdt_ram: single-port-write, single-port-read synchronous memory with
// registered read data; depends on nothing
module kdt_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> src/kdt_walk.sv
// kdt_walk: level-by-level descent sequencer, one split read per level
// then one rank read; depends on kdt_pkg
module kdt_walk import kdt_pkg::*; #(
  parameter int unsigned MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [COORD_W-1:0]     qx_i,
  input  logic signed [COORD_W-1:0]     qy_i,
  input  logic [CNT_W-1:0]              count_i,
  output logic                          ready_o,
  output logic                          split_re_o,
  output logic [$clog2(MAX_POINTS)-1:0] split_raddr_o,
  input  logic [COORD_W-1:0]            split_rdata_i,
  output logic                          rank_re_o,
  output logic [$clog2(MAX_POINTS)-1:0] rank_raddr_o,
  input  logic [RANK_W-1:0]             rank_rdata_i,
  input  logic                          stall_i,
  output res_t                          res_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned NW = AW + 1;

  walk_state_e state_q, state_d;

  logic [NW-1:0]             node_q, node_d, leaf_q, leaf_d;
  logic [CNT_W-1:0]          begin_q, begin_d, end_q, end_d, n_q, n_d;
  logic [PW_W-1:0]           pw_q, pw_d;
  logic                      use_y_q, use_y_d;
  logic                      node_oob_q, node_oob_d, leaf_oob_q, leaf_oob_d;
  logic signed [COORD_W-1:0] qx_q, qx_d, qy_q, qy_d;

  logic [CNT_W-1:0]          n_eff, half;
  logic signed [COORD_W-1:0] coord, split_eff;
  logic                      go_left, more;
  logic [NW-1:0]             node_nx, leaf_nx;
  logic [PW_W-1:0]           pw_nx;
  logic [RANK_W-1:0]         entry;

  // clamp the point count into 1..MAX_POINTS
  always_comb begin
    if (count_i == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(count_i) > 32'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = count_i;
    end
  end

  // one level of descent
  always_comb begin
    half      = (end_q - begin_q) >> 1;
    split_eff = node_oob_q ? '0 : $signed(split_rdata_i);
    coord     = use_y_q ? qy_q : qx_q;
    go_left   = (half != '0) && (coord < split_eff);
    node_nx   = {node_q[NW-2:0], 1'b0} + (go_left ? NW'(1) : NW'(2));
    leaf_nx   = {leaf_q[NW-2:0], ~go_left};
    pw_nx     = {pw_q[PW_W-2:0], 1'b0};
    more      = pw_nx < PW_W'(n_q);
    entry     = leaf_oob_q ? '0 : rank_rdata_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (n_eff > CNT_W'(1)) ? ST_WALK : ST_LEAF;
        end
      end
      ST_WALK: begin
        state_d = more ? ST_WALK : ST_LEAF;
      end
      ST_LEAF: begin
        if (!stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ready_o       = 1'b0;
    split_re_o    = 1'b0;
    split_raddr_o = '0;
    rank_re_o     = 1'b0;
    rank_raddr_o  = '0;
    res_o         = '0;
    case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          split_re_o = n_eff > CNT_W'(1);
          rank_re_o  = n_eff == CNT_W'(1);
        end
      end
      ST_WALK: begin
        split_re_o    = more;
        split_raddr_o = AW'(node_nx);
        rank_re_o     = ~more;
        rank_raddr_o  = AW'(leaf_nx);
      end
      ST_LEAF: begin
        res_o.valid       = ~stall_i;
        res_o.miss        = entry[RANK_W-1];
        res_o.point_index = entry[RANK_W-1] ? '0 : entry[PT_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    node_d     = node_q;
    leaf_d     = leaf_q;
    begin_d    = begin_q;
    end_d      = end_q;
    n_d        = n_q;
    pw_d       = pw_q;
    use_y_d    = use_y_q;
    node_oob_d = node_oob_q;
    leaf_oob_d = leaf_oob_q;
    qx_d       = qx_q;
    qy_d       = qy_q;
    if (state_q == ST_IDLE && start_i) begin
      node_d     = '0;
      leaf_d     = '0;
      begin_d    = '0;
      end_d      = n_eff;
      n_d        = n_eff;
      pw_d       = PW_W'(1);
      use_y_d    = 1'b0;
      node_oob_d = 1'b0;
      leaf_oob_d = 1'b0;
      qx_d       = qx_i;
      qy_d       = qy_i;
    end else if (state_q == ST_WALK) begin
      node_d     = node_nx;
      leaf_d     = leaf_nx;
      pw_d       = pw_nx;
      use_y_d    = ~use_y_q;
      node_oob_d = 32'(node_nx) >= 32'(MAX_POINTS);
      leaf_oob_d = 32'(leaf_nx) >= 32'(MAX_POINTS);
      if (go_left) begin
        end_d = begin_q + half;
      end else begin
        begin_d = begin_q + half;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    leaf_q     <= leaf_d;
    begin_q    <= begin_d;
    end_q      <= end_d;
    n_q        <= n_d;
    pw_q       <= pw_d;
    use_y_q    <= use_y_d;
    node_oob_q <= node_oob_d;
    leaf_oob_q <= leaf_oob_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
  end

endmodule

>>> src/kd_tree_point_locate.sv
// kd_tree_point_locate: 2-d k-d tree point location over split and rank memories
// a query reads the split memory once per tree level, L = ceil(log2 n) levels,
//   and then the rank memory once; the result is then held in the output register
// throughput: one table write per cycle while the walker is idle; no new query until the last is delivered
// reset: point_count returns to 1, no transaction in flight; memories are not cleared
// depends on kdt_pkg, kdt_if, kdt_ram, kdt_walk
module kd_tree_point_locate import kdt_pkg::*; #(
  parameter int unsigned MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic clk_i,
  input  logic rst_ni,
  kdt_in_if.sink    in_i,
  kdt_cfg_if.sink   cfg_i,
  kdt_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  // configuration register; the user must write it only while idle, the block does not enforce this
  logic [CNT_W-1:0] point_count_q, point_count_d;

  // result register parts the walker from the output side
  logic            out_valid_q, out_valid_d;
  logic [PT_W-1:0] out_point_q;
  logic            out_miss_q;

  logic                  in_fire, in_range, stall;
  logic                  split_we, rank_we;
  logic                  split_re, rank_re, walk_ready;
  logic [AW-1:0]         wr_addr, split_raddr, rank_raddr;
  logic [COORD_W-1:0]    split_rdata;
  logic [RANK_W-1:0]     rank_rdata;
  res_t                  res;

  assign cfg_i.ready   = 1'b1;
  assign point_count_d = (cfg_i.valid) ? cfg_i.data : point_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= CNT_RESET;
    end else begin
      point_count_q <= point_count_d;
    end
  end

  // input side: writes finish in the accepting cycle, queries start the walker
  assign in_i.ready = walk_ready;
  assign in_fire    = in_i.valid & in_i.ready;
  assign in_range   = 32'(in_i.entry_index) < 32'(MAX_POINTS);
  assign wr_addr    = AW'(in_i.entry_index);
  assign split_we   = in_fire && in_i.kind == KIND_SPLIT && in_range;
  assign rank_we    = in_fire && in_i.kind == KIND_RANK && in_range;

  // hold the walker at the leaf while an earlier result is still waiting
  assign stall = out_valid_q & ~out_o.ready;

  kdt_ram #(
    .DATA_W (COORD_W),
    .DEPTH  (MAX_POINTS)
  ) u_split_ram (
    .clk_i   (clk_i),
    .we_i    (split_we),
    .waddr_i (wr_addr),
    .wdata_i (in_i.split_value),
    .re_i    (split_re),
    .raddr_i (split_raddr),
    .rdata_o (split_rdata)
  );

  kdt_ram #(
    .DATA_W (RANK_W),
    .DEPTH  (MAX_POINTS)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (wr_addr),
    .wdata_i (in_i.rank_point),
    .re_i    (rank_re),
    .raddr_i (rank_raddr),
    .rdata_o (rank_rdata)
  );

  kdt_walk #(
    .MAX_POINTS (MAX_POINTS)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_fire && in_i.kind == KIND_QUERY),
    .qx_i          (in_i.query_x),
    .qy_i          (in_i.query_y),
    .count_i       (point_count_q),
    .ready_o       (walk_ready),
    .split_re_o    (split_re),
    .split_raddr_o (split_raddr),
    .split_rdata_i (split_rdata),
    .rank_re_o     (rank_re),
    .rank_raddr_o  (rank_raddr),
    .rank_rdata_i  (rank_rdata),
    .stall_i       (stall),
    .res_o         (res)
  );

  // output register: loads a finished result whenever the slot is free or draining
  assign out_valid_d = res.valid | stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_point_q <= res.point_index;
      out_miss_q  <= res.miss;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.point_index = out_point_q;
  assign out_o.miss        = out_miss_q;

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || out_o.ready))
    else $error("result loaded over a pending transaction");

  // a table write leaves the walker idle
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.kind != KIND_QUERY) |=> (!res.valid && walk_ready))
    else $error("table write started a walk");

  // an empty leaf reports point zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.miss) |-> (out_o.point_index == '0))
    else $error("miss with nonzero point index");

  // the walker never accepts while it is delivering
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(walk_ready && res.valid))
    else $error("walker ready while delivering a result");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for kd_tree_point_locate, a short stimulus table
// and then random phases, each result checked against a tree walk kept in the bench
// depends on kdt_pkg, the kdt_if channel interfaces and the rtl of the locator
module tb_top;
  import kdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PTS      = DEF_MAX_POINTS;
  localparam int unsigned SETTLE_CYC   = 16;      // longer than the deepest walk
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned NUM_PHASES   = 16;
  localparam int unsigned HOLD_PHASE   = 2;
  localparam int unsigned CALM_PHASE   = 5;
  localparam int unsigned DRAIN_PHASE  = 6;
  localparam int unsigned HOLD_CYC     = 300;
  localparam int unsigned IDLE_PCT     = 35;

  // the fourth kind code has no meaning and must be dropped by the block
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] split;
    logic signed [RANK_W-1:0]  rank;
  } locate_req_t;

  typedef struct packed {
    logic [PT_W-1:0] point_index;
    logic            miss;
  } locate_res_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_e;

  // one line of the directed table; the expected cell is typed in only where
  // it is obvious, every other query goes through the bench's own tree walk
  typedef struct {
    row_e                      row;
    logic [1:0]                kind;
    logic [CNT_W-1:0]          count;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [COORD_W-1:0] split;
    logic signed [RANK_W-1:0]  rank;
    bit                        typed;
    logic [PT_W-1:0]           pt;
    bit                        miss;
  } step_t;

  logic clk_i;
  logic rst_ni;

  kdt_in_if  in_bus ();
  kdt_cfg_if cfg_bus ();
  kdt_out_if res_bus ();

  kd_tree_point_locate i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (res_bus)
  );

  // bench copy of the tree: tables, which entries hold a value, and the count in force
  logic signed [COORD_W-1:0] split_mem [MAX_PTS];
  logic signed [RANK_W-1:0]  rank_mem  [MAX_PTS];
  bit                        split_set [MAX_PTS];
  bit                        rank_set  [MAX_PTS];
  int unsigned               active_count;
  int unsigned               leaf_span;     // leaves reachable at the current count

  locate_res_t awaited_cells [$];  // cells still owed by the block, oldest first
  locate_res_t front_cell;
  int unsigned errors;
  int unsigned items_sent;         // accepted transactions, ignored kind left out
  bit          calm;               // no idling on either side while set
  bit          stall_req;          // asks the result side for one long hold-off

  step_t plan [27];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // walks the tree as the block should; returns 0 and names the first table
  // entry that still holds no value, so that the caller can fill it first
  function automatic bit find_cell(input logic signed [COORD_W-1:0] qx, qy,
                                   output bit need_rank, output int unsigned need_idx,
                                   output locate_res_t hit);
    int unsigned lo, hi, node, leaf, pw, half;
    bit on_y, go_left;
    logic signed [COORD_W-1:0] coord;
    lo = 0;
    hi = active_count;
    node = 0;
    leaf = 0;
    pw = 1;
    on_y = 1'b0;
    need_rank = 1'b0;
    need_idx = 0;
    hit = '0;
    // one level per doubling: x on even levels, y on odd ones
    while (pw < active_count) begin
      if (!split_set[node]) begin
        need_idx = node;
        return 1'b0;
      end
      half = (hi - lo) / 2;
      coord = on_y ? qy : qx;
      // an empty lower half always sends the walk right
      go_left = (half != 0) && (coord < split_mem[node]);
      if (go_left) begin
        node = 2 * node + 1;
        leaf = 2 * leaf;
        hi = lo + half;
      end else begin
        node = 2 * node + 2;
        leaf = 2 * leaf + 1;
        lo = lo + half;
      end
      pw = pw << 1;
      on_y = !on_y;
    end
    if (!rank_set[leaf]) begin
      need_rank = 1'b1;
      need_idx = leaf;
      return 1'b0;
    end
    // a negative rank entry marks an empty leaf, reported with point index zero
    hit.miss = rank_mem[leaf][RANK_W-1];
    hit.point_index = hit.miss ? '0 : rank_mem[leaf][PT_W-1:0];
    return 1'b1;
  endfunction

  // coordinates lean towards the extremes and values near zero
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3, 4:    return COORD_W'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
      default: return $urandom;
    endcase
  endfunction

  // every field random, the kind and the entry index as given
  function automatic locate_req_t make_item(logic [1:0] kind, logic [IDX_W-1:0] idx);
    locate_req_t r;
    r.kind = kind;
    r.qx = pick_coord();
    r.qy = pick_coord();
    r.idx = idx;
    r.split = pick_coord();
    if ($urandom_range(99) < 15) r.rank = '1;
    else r.rank = RANK_W'($urandom_range(0, MAX_PTS - 1));
    return r;
  endfunction

  // offers one transaction and waits for it to be taken; the bench tables and
  // the owed cells are updated at the edge where it is accepted
  task automatic send(locate_req_t r, bit typed, logic [PT_W-1:0] typed_pt,
                      bit typed_miss);
    locate_res_t hit;
    bit nr;
    int unsigned ni;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.kind        <= r.kind;
    in_bus.query_x     <= r.qx;
    in_bus.query_y     <= r.qy;
    in_bus.entry_index <= r.idx;
    in_bus.split_value <= r.split;
    in_bus.rank_point  <= r.rank;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    case (r.kind)
      KIND_SPLIT: begin
        split_mem[r.idx] = r.split;
        split_set[r.idx] = 1'b1;
      end
      KIND_RANK: begin
        rank_mem[r.idx] = r.rank;
        rank_set[r.idx] = 1'b1;
      end
      KIND_QUERY: begin
        if (typed) begin
          hit.point_index = typed_pt;
          hit.miss = typed_miss;
        end else begin
          void'(find_cell(r.qx, r.qy, nr, ni, hit));
        end
        awaited_cells = {awaited_cells, hit};
      end
      default: ;
    endcase
    if (r.kind != KIND_UNUSED) items_sent++;
  endtask

  // a query goes out only once every entry on its path holds a value; missing
  // entries are written first with random contents
  task automatic ask(locate_req_t q, bit typed, logic [PT_W-1:0] typed_pt,
                     bit typed_miss);
    locate_res_t hit;
    bit nr;
    int unsigned ni;
    while (!find_cell(q.qx, q.qy, nr, ni, hit))
      send(make_item(nr ? KIND_RANK : KIND_SPLIT, IDX_W'(ni)), 1'b0, '0, 1'b0);
    send(q, typed, typed_pt, typed_miss);
  endtask

  // the count is only changed with nothing in flight: all cells back, then a
  // settling wait for a table write that might still be in flight
  task automatic set_count(logic [CNT_W-1:0] n);
    in_bus.valid <= 1'b0;
    while (awaited_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= n;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    // zero acts as one, anything past the table size as the table size
    if (n == 0) active_count = 1;
    else if (n > MAX_PTS) active_count = MAX_PTS;
    else active_count = n;
    leaf_span = 1;
    while (leaf_span < active_count) leaf_span = leaf_span << 1;
  endtask

  // result side: random back-pressure, one long hold-off on request, none when calm
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (calm) begin
        res_bus.ready <= 1'b1;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // result checker: each returned cell against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (awaited_cells.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got point_index %0d miss %0b",
                 $time, res_bus.point_index, res_bus.miss);
      end else begin
        front_cell = awaited_cells.pop_front();
        if (res_bus.point_index !== front_cell.point_index) begin
          errors++;
          $display("%0t: point_index mismatch, expected %0d, got %0d",
                   $time, front_cell.point_index, res_bus.point_index);
        end
        if (res_bus.miss !== front_cell.miss) begin
          errors++;
          $display("%0t: miss mismatch, expected %0b, got %0b",
                   $time, front_cell.miss, res_bus.miss);
        end
      end
    end
  end

  // watchdog on the whole run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    locate_req_t req;
    int unsigned phase_start, ni, roll;
    bit held, drained;
    logic [CNT_W-1:0] phase_counts [NUM_PHASES];

    errors = 0;
    items_sent = 0;
    calm = 1'b0;
    stall_req = 1'b0;
    held = 1'b0;
    drained = 1'b0;
    active_count = 1;   // the count after reset
    leaf_span = 1;

    // count 0 and 2047 lie outside the legal range and are clamped by the block
    phase_counts = '{11'd1024, 11'd5, 11'd17, 11'd1, 11'd2, 11'd100, 11'd2047, 11'd64,
                     11'd33, 11'd0, 11'd513, 11'd3, 11'd7, 11'd1023, 11'd256, 11'd1000};

    // row, kind, count, index, x, y, split, rank, typed, point, miss
    plan = '{
      // single point straight after reset: the only leaf decides
      '{ROW_ITEM, KIND_RANK,   0,    0, 0,     0,     0,     5,    0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, 0,     0,     0,     0,    1, 5,    0},
      // empty leaf
      '{ROW_ITEM, KIND_RANK,   0,    0, 0,     0,     0,     -1,   0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, Q_MIN, Q_MAX, 0,     0,    1, 0,    1},
      // the unused kind must not touch the rank table
      '{ROW_ITEM, KIND_UNUSED, 0,    0, -1,    -1,    -1,    7,    0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, Q_MAX, Q_MIN, 0,     0,    1, 0,    1},
      // a count of zero behaves as one
      '{ROW_CFG,  KIND_UNUSED, 0,    0, 0,     0,     0,     0,    0, 0,    0},
      '{ROW_ITEM, KIND_RANK,   0,    0, 0,     0,     0,     1023, 0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, -1,    -1,    0,     0,    1, 1023, 0},
      // two points: one x split, strict less goes left
      '{ROW_CFG,  KIND_UNUSED, 2,    0, 0,     0,     0,     0,    0, 0,    0},
      '{ROW_ITEM, KIND_SPLIT,  0,    0, 0,     0,     0,     0,    0, 0,    0},
      '{ROW_ITEM, KIND_RANK,   0,    1, 0,     0,     0,     4,    0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, -1,    0,     0,     0,    1, 1023, 0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, 0,     0,     0,     0,    1, 4,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, Q_MIN, 0,     0,     0,    1, 1023, 0},
      // split at the extremes of the coordinate range
      '{ROW_ITEM, KIND_SPLIT,  0,    0, 0,     0,     Q_MIN, 0,    0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, Q_MIN, Q_MAX, 0,     0,    1, 4,    0},
      '{ROW_ITEM, KIND_SPLIT,  0,    0, 0,     0,     Q_MAX, 0,    0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, Q_MAX, Q_MIN, 0,     0,    1, 4,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, 32'sh7FFF_FFFE, Q_MIN, 0, 0, 1, 1023, 0},
      // three points: a zero half forces the walk right
      '{ROW_CFG,  KIND_UNUSED, 3,    0, 0,     0,     0,     0,    0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, 0,     0,     0,     0,    0, 0,    0},
      // count past the table size, deepest tree and the last table entries
      '{ROW_CFG,  KIND_UNUSED, 2047, 0, 0,     0,     0,     0,    0, 0,    0},
      '{ROW_ITEM, KIND_SPLIT,  0, 1023, 0,     0,     Q_MAX, 0,    0, 0,    0},
      '{ROW_ITEM, KIND_RANK,   0, 1023, 0,     0,     0,     1023, 0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, Q_MAX, Q_MAX, 0,     0,    0, 0,    0},
      '{ROW_ITEM, KIND_QUERY,  0,    0, Q_MIN, Q_MIN, 0,     0,    0, 0,    0}
    };

    // every input known from the first instant
    rst_ni              <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.kind         <= KIND_QUERY;
    in_bus.query_x      <= '0;
    in_bus.query_y      <= '0;
    in_bus.entry_index  <= '0;
    in_bus.split_value  <= '0;
    in_bus.rank_point   <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.data        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].row == ROW_CFG) begin
        set_count(plan[i].count);
      end else begin
        req = '{plan[i].kind, plan[i].qx, plan[i].qy, plan[i].idx, plan[i].split,
                plan[i].rank};
        if (req.kind == KIND_QUERY) ask(req, plan[i].typed, plan[i].pt, plan[i].miss);
        else send(req, 1'b0, '0, 1'b0);
      end
    end

    // random phases, one count each; tables carry over from phase to phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_count(phase_counts[p]);
      calm = (p == CALM_PHASE);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // result side holds off while queries keep coming, so the block backs up
        if (p == HOLD_PHASE && !held && items_sent - phase_start >= 20) begin
          held = 1'b1;
          stall_req = 1'b1;
        end
        // query side stops until every owed cell is back
        if (p == DRAIN_PHASE && !drained && items_sent - phase_start >= PHASE_ITEMS / 2)
        begin
          drained = 1'b1;
          in_bus.valid <= 1'b0;
          @(posedge clk_i);
          while (awaited_cells.size() != 0) @(posedge clk_i);
        end
        roll = $urandom_range(99);
        // entry writes mostly land inside the part of the tree in use
        ni = ($urandom_range(3) != 0) ? $urandom_range(0, leaf_span - 1)
                                      : $urandom_range(0, MAX_PTS - 1);
        if (roll < 5) begin
          send(make_item(KIND_UNUSED, IDX_W'($urandom)), 1'b0, '0, 1'b0);
        end else if (roll < 17) begin
          send(make_item(KIND_SPLIT, IDX_W'(ni)), 1'b0, '0, 1'b0);
        end else if (roll < 29) begin
          send(make_item(KIND_RANK, IDX_W'(ni)), 1'b0, '0, 1'b0);
        end else begin
          req = make_item(KIND_QUERY, IDX_W'($urandom));
          // now and then a coordinate equal to a stored split, to hit the tie
          ni = $urandom_range(0, MAX_PTS - 1);
          if (split_set[ni] && $urandom_range(3) == 0) req.qx = split_mem[ni];
          ni = $urandom_range(0, MAX_PTS - 1);
          if (split_set[ni] && $urandom_range(3) == 0) req.qy = split_mem[ni];
          ask(req, 1'b0, '0, 1'b0);
        end
      end
    end
    calm = 1'b0;

    // wind down: all cells back, then a short settle for any stray result
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
